// File: sv/lfpdc_pkg.sv
// Shared types and constants for the light frame parser / dimmer curve block.
// No dependencies; imported by every RTL module of the block.
`default_nettype none

package lfpdc_pkg;

    localparam int unsigned LEVEL_W = 8;
    localparam int unsigned DUTY_W  = 16;

    localparam logic [7:0] HEADER_RESET = 8'd131;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_CHANNEL_PAIR = 1'b0,
        CFG_HEADER_VALUE = 1'b1
    } t_cfg_addr;

    // two stored levels picked for one output transaction
    typedef struct packed {
        logic [LEVEL_W-1:0] first;
        logic [LEVEL_W-1:0] second;
    } t_level_pair;

endpackage

`default_nettype wire

// File: sv/lfpdc_parser.sv
// Frame parser: header detection, level store, configuration registers and
// the stage register holding the selected level pair. Uses lfpdc_pkg.
`default_nettype none

module lfpdc_parser #(
    parameter int unsigned FRAME_BYTES = 4
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_cfg_we,
    input  wire lfpdc_pkg::t_cfg_addr i_cfg_addr,
    input  wire [7:0]                i_cfg_wdata,
    input  wire                      i_valid,
    output logic                     o_ready,
    input  wire [7:0]                i_byte,
    output logic                     o_valid,
    input  wire                      i_ready,
    output lfpdc_pkg::t_level_pair   o_pair
);
    import lfpdc_pkg::*;

    localparam int unsigned POS_W  = $clog2(FRAME_BYTES + 2);
    localparam int unsigned SLOT_W = $clog2(FRAME_BYTES);

    logic                r_pair_sel;
    logic [7:0]          r_header;
    logic [POS_W-1:0]    r_pos;
    logic [LEVEL_W-1:0]  r_lvl [FRAME_BYTES];
    logic                r_valid;
    t_level_pair         r_pair;

    logic                w_accept;
    logic                w_start;
    logic                w_store;
    logic                w_emit;
    logic [SLOT_W-1:0]   w_slot;
    logic [LEVEL_W-1:0]  w_lvl_at [4];
    logic [POS_W-1:0]    n_pos;
    t_level_pair         n_pair;

    // levels beyond the store read as zero
    for (genvar k = 0; k < 4; k++) begin : g_lvl_at
        if (k < FRAME_BYTES) begin : g_in
            assign w_lvl_at[k] = r_lvl[k];
        end else begin : g_out
            assign w_lvl_at[k] = '0;
        end
    end

    assign o_ready  = !r_valid || i_ready;
    assign w_accept = i_valid && o_ready;
    assign w_start  = (r_pos == '0) && (i_byte == r_header);
    assign w_store  = (r_pos != '0) && (r_pos <= POS_W'(FRAME_BYTES));
    assign w_emit   = w_accept && !w_start && !w_store;
    assign w_slot   = SLOT_W'(r_pos - POS_W'(1));

    always_comb begin
        n_pos = r_pos;
        if (w_accept) begin
            if (w_start) begin
                n_pos = POS_W'(1);
            end else if (w_store) begin
                n_pos = r_pos + POS_W'(1);
            end else begin
                n_pos = '0;
            end
        end
        n_pair.first  = r_pair_sel ? w_lvl_at[2] : w_lvl_at[0];
        n_pair.second = r_pair_sel ? w_lvl_at[3] : w_lvl_at[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_sel <= 1'b0;
            r_header   <= HEADER_RESET;
            r_pos      <= '0;
            r_valid    <= 1'b0;
            for (int i = 0; i < FRAME_BYTES; i++) begin
                r_lvl[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_CHANNEL_PAIR: r_pair_sel <= i_cfg_wdata[0];
                    CFG_HEADER_VALUE: r_header   <= i_cfg_wdata;
                    default: ;
                endcase
            end
            r_pos <= n_pos;
            for (int i = 0; i < FRAME_BYTES; i++) begin
                if (w_accept && w_store && (w_slot == SLOT_W'(i))) begin
                    r_lvl[i] <= i_byte;
                end
            end
            if (w_emit) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_pair <= n_pair;
        end
    end

    assign o_valid = r_valid;
    assign o_pair  = r_pair;

endmodule

`default_nettype wire

// File: sv/lfpdc_curve.sv
// Brightness curve for two levels and the output register of the stream.
// Uses lfpdc_pkg for the level pair type and widths.
`default_nettype none

module lfpdc_curve (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_ready,
    input  wire lfpdc_pkg::t_level_pair i_pair,
    output logic                   o_valid,
    input  wire                    i_ready,
    output logic [31:0]            o_data
);
    import lfpdc_pkg::*;

    localparam int unsigned RCP_SHIFT = 20;
    localparam logic [33:0] RCP_1000  = 34'd1048;   // floor(2^20 / 1000)
    localparam logic [33:0] RCP_100   = 34'd10485;  // floor(2^20 / 100)

    // floor(d * num / den) by reciprocal; estimate is low by at most one
    function automatic logic [16:0] f_mul_div(
        input logic [7:0]  d,
        input logic [33:0] num,
        input logic [33:0] rcp,
        input logic [33:0] den
    );
        logic [33:0] prod;
        logic [33:0] q;
        prod = 34'(d) * num;
        q    = (prod * rcp) >> RCP_SHIFT;
        if ((q + 34'd1) * den <= prod) begin
            q = q + 34'd1;
        end
        return q[16:0];
    endfunction

    function automatic logic [DUTY_W-1:0] f_curve(input logic [LEVEL_W-1:0] d);
        logic [16:0] v;
        if (d < 8'd3) begin
            v = f_mul_div(d, 34'd1666, RCP_1000, 34'd1000);
        end else if (d < 8'd10) begin
            v = f_mul_div(d, 34'd8857, RCP_1000, 34'd1000) - 17'd21;
        end else if (d < 8'd45) begin
            v = f_mul_div(d, 34'd4463, RCP_100, 34'd100) - 17'd379;
        end else if (d < 8'd100) begin
            v = 17'(d) * 17'd132 - 17'd4312;
        end else if (d < 8'd185) begin
            v = 17'(d) * 17'd282 - 17'd19311;
        end else begin
            v = 17'(d) * 17'd467 - 17'd53484;
        end
        return v[16] ? {DUTY_W{1'b1}} : v[DUTY_W-1:0];
    endfunction

    logic        r_valid;
    logic [31:0] r_data;
    logic        w_load;
    logic [31:0] n_data;

    assign o_ready = !r_valid || i_ready;
    assign w_load  = i_valid && o_ready;
    assign n_data  = {f_curve(i_pair.second), f_curve(i_pair.first)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// File: sv/light_frame_parser_dimmer_curve.sv
// Top level of the light frame parser with dimmer curve.
// Instantiates lfpdc_parser and lfpdc_curve; uses lfpdc_pkg.
`default_nettype none

// Takes one received byte per transaction on the slave stream, one per cycle
// while the input is not stalled. While idle, a byte equal to header_value
// opens a frame and the next FRAME_BYTES bytes are stored as channel levels.
// The byte after the last data byte (whatever it is), or any non-header byte
// while idle, closes the frame and yields one master transaction: two 16-bit
// duties from stored levels 0-1 or 2-3 (channel_pair), each mapped through a
// six-segment brightness curve and saturated. Bytes that open or fill a frame
// yield nothing. A result passes through two registers: one holds the parser's
// level pair, one holds the curve output. The input side stalls only when both
// registers hold results not yet taken.
// Configuration writes take effect at once and belong in idle periods.

module light_frame_parser_dimmer_curve #(
    parameter int unsigned FRAME_BYTES = 4
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire [0:0]   i_cfg_addr,     // 0: channel_pair, 1: header_value
    input  wire [7:0]   i_cfg_wdata,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [7:0]   s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata    // [15:0] level_first, [31:16] level_second
);
    import lfpdc_pkg::*;

    logic        w_pair_valid;
    logic        w_pair_ready;
    t_level_pair w_pair;

    lfpdc_parser #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (t_cfg_addr'(i_cfg_addr)),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_byte      (s_axis_tdata),
        .o_valid     (w_pair_valid),
        .i_ready     (w_pair_ready),
        .o_pair      (w_pair)
    );

    lfpdc_curve u_curve (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_pair_valid),
        .o_ready (w_pair_ready),
        .i_pair  (w_pair),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire

// File: sv/lfpdc_checker.sv
// Port-level checks for light_frame_parser_dimmer_curve, bound to the top.
// No package dependency.
`default_nettype none

module lfpdc_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [31:0] m_axis_tdata
);

    // output register empties on reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // a fresh result must come from an accepted input transaction
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result without closing byte");

    // input back-pressure only when the output is full
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with empty output");

endmodule

bind light_frame_parser_dimmer_curve lfpdc_checker u_lfpdc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// File: test/light_frame_parser_dimmer_curve_test.sv
// Testbench for light_frame_parser_dimmer_curve: byte stream in, curve-mapped duty pairs out.
// Predicts each duty pair from the accepted bytes and the register writes it observes.
// Depends on lfpdc_pkg and the light_frame_parser_dimmer_curve RTL.
`timescale 1ns / 100ps

module light_frame_parser_dimmer_curve_test;
    import lfpdc_pkg::*;

    localparam int unsigned FRAME_BYTES = 4;
    localparam int unsigned RUN_LIMIT   = 200000;
    localparam int unsigned ERR_SHOWN   = 10;

    typedef struct packed {
        logic [15:0] second;
        logic [15:0] first;
    } t_duty_pair;

    // curve segment edges, used to bias random levels
    localparam logic [7:0] EDGE_LEVELS [14] = '{
        8'd0, 8'd1, 8'd2, 8'd3, 8'd9, 8'd10, 8'd44, 8'd45,
        8'd99, 8'd100, 8'd184, 8'd185, 8'd254, 8'd255
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [0:0]  i_cfg_addr;
    logic [7:0]  i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;    // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;    // [15:0] level_first, [31:16] level_second

    // dimmer state tracked alongside the block
    logic        cfg_pair;
    logic [7:0]  cfg_header;
    int unsigned frame_pos;
    logic [7:0]  stored_levels [FRAME_BYTES];
    t_duty_pair  duty_q [$];

    int unsigned err_count;
    int unsigned bytes_sent;
    int unsigned watch_cycles;
    bit          tx_gaps_on;
    bit          rx_stalls_on;
    int unsigned rx_hold;

    light_frame_parser_dimmer_curve #(
        .FRAME_BYTES(FRAME_BYTES)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [15:0] dimmer_duty(input logic [7:0] lvl);
        int unsigned d;
        int unsigned v;
        d = lvl;
        if (d < 3)
            v = d * 1666 / 1000;
        else if (d < 10)
            v = d * 8857 / 1000 - 21;
        else if (d < 45)
            v = d * 4463 / 100 - 379;
        else if (d < 100)
            v = d * 132 - 4312;
        else if (d < 185)
            v = d * 282 - 19311;
        else
            v = d * 467 - 53484;
        if (v > 65535)
            v = 65535;
        return v[15:0];
    endfunction

    function automatic logic [7:0] pick_level();
        if ($urandom_range(0, 2) == 0)
            return EDGE_LEVELS[$urandom_range(0, 13)];
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic note_mismatch(input string what, input t_duty_pair want,
                                 input t_duty_pair got);
        err_count++;
        if (err_count <= ERR_SHOWN)
            $display("%0t %s: expected first=%0d second=%0d, got first=%0d second=%0d",
                     $time, what, want.first, want.second, got.first, got.second);
    endtask

    // Output check first, then register and byte updates: a result never leaves
    // in the same cycle as the byte that causes it.
    always @(posedge i_clk) begin : duty_monitor
        logic [7:0] rx;
        logic [2:0] base;
        t_duty_pair got;
        t_duty_pair want;
        if (!i_rst_n) begin
            cfg_pair   = 1'b0;
            cfg_header = HEADER_RESET;
            frame_pos  = 0;
            foreach (stored_levels[k])
                stored_levels[k] = '0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.first  = m_axis_tdata[15:0];
                got.second = m_axis_tdata[31:16];
                if (duty_q.size() == 0) begin
                    note_mismatch("unexpected transaction", '0, got);
                end else begin
                    want = duty_q.pop_front();
                    if (got.first !== want.first || got.second !== want.second)
                        note_mismatch("duty mismatch", want, got);
                end
            end
            if (i_cfg_we) begin
                case (t_cfg_addr'(i_cfg_addr))
                    CFG_CHANNEL_PAIR: cfg_pair   = i_cfg_wdata[0];
                    CFG_HEADER_VALUE: cfg_header = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                rx = s_axis_tdata;
                if (frame_pos == 0 && rx == cfg_header) begin
                    frame_pos = 1;
                end else if (frame_pos >= 1 && frame_pos <= FRAME_BYTES) begin
                    stored_levels[frame_pos-1] = rx;
                    frame_pos++;
                end else begin
                    // closing byte, or a stray byte while idle
                    frame_pos   = 0;
                    base        = {1'b0, cfg_pair, 1'b0};
                    want.first  = dimmer_duty(stored_levels[base]);
                    want.second = dimmer_duty(stored_levels[base+1]);
                    duty_q.push_back(want);
                end
            end
        end
    end

    // receiver: random short stalls, or one long hold when asked
    initial begin : duty_receiver
        int unsigned stall_left;
        stall_left    = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold > 0) begin
                stall_left = rx_hold;
                rx_hold    = 0;
            end else if (stall_left == 0 && rx_stalls_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 4);
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        for (watch_cycles = 0; watch_cycles < RUN_LIMIT; watch_cycles++)
            @(posedge i_clk);
        $display("status: fail");
        $finish;
    end

    // Leaves tvalid high on return; the next call or pause_input decides what follows.
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        bytes_sent++;
    endtask

    task automatic pause_input(input int unsigned cycles);
        s_axis_tvalid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // stop sending, let every expected result out, then cover the pipeline depth
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge i_clk);
        while (duty_q.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_addr addr, input logic [7:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_frame(input logic [7:0] l0, input logic [7:0] l1,
                              input logic [7:0] l2, input logic [7:0] l3,
                              input logic [7:0] closer);
        send_byte(cfg_header);
        send_byte(l0);
        send_byte(l1);
        send_byte(l2);
        send_byte(l3);
        send_byte(closer);
    endtask

    // mostly whole frames with random content; some cut-short frames and stray bytes
    task automatic send_mixed_traffic(input int unsigned n_items);
        int unsigned stop_at;
        int unsigned pick;
        int unsigned cnt;
        logic [7:0]  closer;
        stop_at = bytes_sent + n_items;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                closer = ($urandom_range(0, 3) == 0) ? cfg_header : 8'($urandom_range(0, 255));
                send_frame(pick_level(), pick_level(), pick_level(), pick_level(), closer);
            end else if (pick == 7) begin
                cnt = $urandom_range(0, 3);
                send_byte(cfg_header);
                repeat (cnt) send_byte(pick_level());
            end else begin
                cnt = $urandom_range(1, 3);
                repeat (cnt) send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic test_default_frames();
        send_byte(8'd0);
        send_frame(8'd0, 8'd255, 8'd2, 8'd3, 8'h55);
        send_frame(8'd9, 8'd10, 8'd44, 8'd45, HEADER_RESET);
        // header value as data, level 100 and both sides of the 184/185 segment edge
        send_frame(HEADER_RESET, 8'd100, 8'd184, 8'd185, 8'd7);
        send_byte(8'd255);
        drain_results();
    endtask

    task automatic test_register_settings();
        write_reg(CFG_CHANNEL_PAIR, 8'd1);
        send_frame(8'd1, 8'd2, 8'd3, 8'd9, 8'd0);
        send_mixed_traffic(90);
        drain_results();

        write_reg(CFG_HEADER_VALUE, 8'd0);
        write_reg(CFG_CHANNEL_PAIR, 8'd0);
        send_mixed_traffic(90);
        drain_results();

        write_reg(CFG_HEADER_VALUE, 8'd255);
        write_reg(CFG_CHANNEL_PAIR, 8'hFF);
        send_mixed_traffic(90);
        drain_results();

        // upper bits of the pair register are dropped
        write_reg(CFG_CHANNEL_PAIR, 8'hFE);
        write_reg(CFG_HEADER_VALUE, 8'($urandom_range(0, 255)));
        send_mixed_traffic(90);
        drain_results();

        write_reg(CFG_CHANNEL_PAIR, 8'($urandom_range(0, 255)));
        write_reg(CFG_HEADER_VALUE, 8'($urandom_range(0, 255)));
        send_mixed_traffic(90);
        drain_results();
    endtask

    // receiver holds off long enough that both result registers fill and input stalls
    task automatic test_output_holdoff();
        rx_hold = 60;
        repeat (12) send_byte(cfg_header + 8'd1);
        send_mixed_traffic(30);
        drain_results();
    endtask

    task automatic test_sender_pause();
        send_frame(pick_level(), pick_level(), pick_level(), pick_level(), 8'hAA);
        pause_input(1);
        while (duty_q.size() != 0)
            @(posedge i_clk);
        send_byte(cfg_header ^ 8'h5A);
        send_mixed_traffic(30);
        drain_results();
    endtask

    task automatic test_full_rate();
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        write_reg(CFG_CHANNEL_PAIR, 8'($urandom_range(0, 1)));
        write_reg(CFG_HEADER_VALUE, HEADER_RESET);
        send_mixed_traffic(100);
        drain_results();
    endtask

    initial begin
        err_count     = 0;
        bytes_sent    = 0;
        rx_hold       = 0;
        tx_gaps_on    = 1'b1;
        rx_stalls_on  = 1'b1;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_addr    <= CFG_CHANNEL_PAIR;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_frames();
        test_register_settings();
        test_output_holdoff();
        test_sender_pause();
        test_full_rate();

        err_count += duty_q.size();
        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: sim.f
sv/lfpdc_pkg.sv
sv/lfpdc_parser.sv
sv/lfpdc_curve.sv
sv/light_frame_parser_dimmer_curve.sv
sv/lfpdc_checker.sv
test/light_frame_parser_dimmer_curve_test.sv
